// ===== hdl/masked_signature_scanner_top_macros.svh =====
// ----------------------------------------------------------------------------
// Masked signature scanner assertion macros
// Shorthand for clocked, reset-qualified assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MASKED_SIGNATURE_SCANNER_TOP_MACROS_SVH
`define MASKED_SIGNATURE_SCANNER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MSS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// Masked signature scanner package
// Shared widths, register codes and word types of the scanner.
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam int SIG_SLOTS       = 4;
    localparam int NUM_SIGS_DEF    = 4;
    localparam int MAX_SIG_LEN_DEF = 8;
    localparam int ADDR_BITS       = 48;
    localparam int BYTE_BITS       = 8;
    localparam int POS_BITS        = 32;
    localparam int LEN_BITS        = 4;
    localparam int OFF_BITS        = 16;
    localparam int REL_BITS        = POS_BITS + 1;
    localparam int SEL_BITS        = 3;
    localparam int IDX_BITS        = 2;
    localparam int CFG_IDX_BITS    = 4;
    localparam int CFG_DATA_BITS   = 64;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PATTERN_ZERO  = 4'd0,
        CFG_PATTERN_ONE   = 4'd1,
        CFG_PATTERN_TWO   = 4'd2,
        CFG_PATTERN_THREE = 4'd3,
        CFG_CARE_MASKS    = 4'd4,
        CFG_LENGTHS       = 4'd5,
        CFG_OFFSETS       = 4'd6,
        CFG_BASE_ADDRESS  = 4'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [SIG_SLOTS-1:0][63:0] pat;
        logic [31:0]                care;
        logic [15:0]                lens;
        logic [63:0]                offs;
        logic [ADDR_BITS-1:0]       base;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_BITS-1:0] image_byte;
        logic                 end_of_image;
    } t_in_word;

    typedef struct packed {
        logic [IDX_BITS-1:0]  sig_index;
        logic                 found;
        logic [ADDR_BITS-1:0] match_address;
        logic                 last_result;
    } t_out_word;

    // Final per-signature outcome of one image, handed to the result buffer.
    typedef struct packed {
        logic [SIG_SLOTS-1:0]                found;
        logic [SIG_SLOTS-1:0][ADDR_BITS-1:0] addr;
    } t_rep;

endpackage

// ===== hdl/mss_cell.sv =====
// ----------------------------------------------------------------------------
// Masked signature scanner window cell
// Holds one window byte, passes it on at each word, and compares the byte it
// is about to hold against the pattern byte every signature expects there.
// ----------------------------------------------------------------------------
module mss_cell #(
    parameter int CELL_POS = 0,
    parameter int NUM_SIGS = mss_pkg::NUM_SIGS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_shift,
    input  logic [mss_pkg::BYTE_BITS-1:0]           i_byte,
    input  mss_pkg::t_cfg                           i_cfg,
    input  logic [NUM_SIGS-1:0][mss_pkg::LEN_BITS-1:0] i_len,
    output logic [mss_pkg::BYTE_BITS-1:0]           o_byte,
    output logic [NUM_SIGS-1:0]                     o_eq
);

    localparam logic [mss_pkg::LEN_BITS-1:0] POS = mss_pkg::LEN_BITS'(CELL_POS);

    logic [mss_pkg::BYTE_BITS-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

    // The cell k places back meets pattern byte len-1-k; beyond the
    // signature's length it always agrees.
    always_comb begin
        logic [mss_pkg::LEN_BITS-1:0]       w_idx;
        logic [mss_pkg::SEL_BITS-1:0]       w_sel;
        logic [7:0][mss_pkg::BYTE_BITS-1:0] w_pbytes;
        logic [7:0]                         w_care;
        for (int s = 0; s < NUM_SIGS; s++) begin
            w_idx    = i_len[s] - POS - 4'd1;
            w_sel    = w_idx[mss_pkg::SEL_BITS-1:0];
            w_pbytes = i_cfg.pat[s];
            w_care   = i_cfg.care[8*s +: 8];
            if (POS >= i_len[s]) begin
                o_eq[s] = 1'b1;
            end else begin
                o_eq[s] = !w_care[w_sel] || (i_byte == w_pbytes[w_sel]);
            end
        end
    end

endmodule

// ===== hdl/mss_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Masked signature scanner configuration registers
// Decodes register writes into the pattern, mask, length, offset and base bank.
// ----------------------------------------------------------------------------
module mss_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_we,
    input  logic [mss_pkg::CFG_IDX_BITS-1:0]   i_index,
    input  logic [mss_pkg::CFG_DATA_BITS-1:0]  i_data,
    output mss_pkg::t_cfg                      o_cfg
);

    mss_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_we) begin
            unique case (i_index) inside
                mss_pkg::CFG_PATTERN_ZERO, mss_pkg::CFG_PATTERN_ONE,
                mss_pkg::CFG_PATTERN_TWO, mss_pkg::CFG_PATTERN_THREE: begin
                    r_cfg.pat[i_index[mss_pkg::IDX_BITS-1:0]] <= i_data;
                end
                mss_pkg::CFG_CARE_MASKS: begin
                    r_cfg.care <= i_data[31:0];
                end
                mss_pkg::CFG_LENGTHS: begin
                    r_cfg.lens <= i_data[15:0];
                end
                mss_pkg::CFG_OFFSETS: begin
                    r_cfg.offs <= i_data;
                end
                mss_pkg::CFG_BASE_ADDRESS: begin
                    r_cfg.base <= i_data[mss_pkg::ADDR_BITS-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/mss_report.sv =====
// ----------------------------------------------------------------------------
// Masked signature scanner result buffer
// Holds one image's outcome and hands it out one signature per word.
// ----------------------------------------------------------------------------
module mss_report #(
    parameter int NUM_SIGS = mss_pkg::NUM_SIGS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  mss_pkg::t_rep      i_rep,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_stall,
    output mss_pkg::t_out_word o_data
);

    localparam logic [mss_pkg::IDX_BITS-1:0] LAST = mss_pkg::IDX_BITS'(NUM_SIGS - 1);

    logic                                r_busy;
    logic [mss_pkg::IDX_BITS-1:0]        r_idx;
    logic [mss_pkg::SIG_SLOTS-1:0]       r_found;
    logic [mss_pkg::ADDR_BITS-1:0]       r_addr [mss_pkg::SIG_SLOTS];
    logic                                w_take;
    logic                                w_last;

    assign w_take = r_busy && !i_stall;
    assign w_last = (r_idx == LAST);
    assign o_free = !r_busy || (w_take && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_found <= i_rep.found;
            for (int s = 0; s < mss_pkg::SIG_SLOTS; s++) begin
                r_addr[s] <= i_rep.addr[s];
            end
        end
    end

    assign o_valid              = r_busy;
    assign o_data.sig_index     = r_idx;
    assign o_data.found         = r_found[r_idx];
    assign o_data.match_address = r_addr[r_idx];
    assign o_data.last_result   = w_last;

endmodule

// ===== hdl/masked_signature_scanner_top.sv =====
// ----------------------------------------------------------------------------
// Masked signature scanner
// Streams an image a byte per word through a row of window cells and reports,
// at the end of the image, where each masked signature first matched.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            word
//  in        input      i_in_valid/o_in_stall  image_byte, end_of_image
//  out       output     o_out_valid/i_out_stall sig_index, found, address, last
//  cfg       input      i_cfg_valid/o_cfg_ready register index, write data
//
// One byte per unstalled cycle: the window cells shift and compare in the cycle
// a word is taken, and the address sum is added in the cycle after. An
// end-of-image word yields NUM_SIGS result words, one per unstalled cycle from
// the result buffer; a second end word held behind a full buffer stalls input.
// Reset is synchronous and clears the registers and the scan state.
// ----------------------------------------------------------------------------
module masked_signature_scanner_top #(
    parameter int NUM_SIGS    = mss_pkg::NUM_SIGS_DEF,
    parameter int MAX_SIG_LEN = mss_pkg::MAX_SIG_LEN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  mss_pkg::t_in_word                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output mss_pkg::t_out_word                 o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mss_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [mss_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int LB = mss_pkg::LEN_BITS;
    localparam int RB = mss_pkg::REL_BITS;
    localparam int AB = mss_pkg::ADDR_BITS;
    localparam logic [LB-1:0] MAX_LEN = LB'(MAX_SIG_LEN);

    mss_pkg::t_cfg                  w_cfg;
    logic                           w_take;
    logic [NUM_SIGS-1:0][LB-1:0]    w_len;
    logic [mss_pkg::BYTE_BITS-1:0]  w_chain [MAX_SIG_LEN];
    logic [NUM_SIGS-1:0]            w_eq [MAX_SIG_LEN];
    logic [NUM_SIGS-1:0]            w_match;
    logic [NUM_SIGS-1:0]            w_hit;
    logic [RB-1:0]                  w_rel [NUM_SIGS];
    logic [AB-1:0]                  w_sum [NUM_SIGS];
    logic [mss_pkg::POS_BITS-1:0]   w_pos_next;
    logic                           w_rep_free;
    logic                           w_load;
    mss_pkg::t_rep                  w_rep;

    logic [mss_pkg::POS_BITS-1:0]   r_pos;
    logic [NUM_SIGS-1:0]            r_found;
    logic [NUM_SIGS-1:0]            r_pend;
    logic [NUM_SIGS-1:0]            r_rep_found;
    logic                           r_s2_end;
    logic [RB-1:0]                  r_rel [NUM_SIGS];
    logic [AB-1:0]                  r_addr [NUM_SIGS];

    assign o_cfg_ready = 1'b1;

    mss_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    assign w_take     = i_in_valid && !o_in_stall;
    assign w_load     = r_s2_end && w_rep_free;
    assign o_in_stall = r_s2_end && !w_rep_free;

    // Lengths above the window size are clamped to it.
    always_comb begin
        for (int s = 0; s < NUM_SIGS; s++) begin
            w_len[s] = (w_cfg.lens[LB*s +: LB] > MAX_LEN) ? MAX_LEN : w_cfg.lens[LB*s +: LB];
        end
    end

    assign w_chain[0] = i_in_data.image_byte;

    for (genvar k = 0; k < MAX_SIG_LEN; k++) begin : g_cell
        if (k == MAX_SIG_LEN - 1) begin : g_tail
            mss_cell #(.CELL_POS(k), .NUM_SIGS(NUM_SIGS)) u_cell (
                .i_clk   (i_clk),
                .i_shift (w_take),
                .i_byte  (w_chain[k]),
                .i_cfg   (w_cfg),
                .i_len   (w_len),
                .o_byte  (),
                .o_eq    (w_eq[k])
            );
        end else begin : g_body
            mss_cell #(.CELL_POS(k), .NUM_SIGS(NUM_SIGS)) u_cell (
                .i_clk   (i_clk),
                .i_shift (w_take),
                .i_byte  (w_chain[k]),
                .i_cfg   (w_cfg),
                .i_len   (w_len),
                .o_byte  (w_chain[k+1]),
                .o_eq    (w_eq[k])
            );
        end
    end

    // The byte count holds once it reaches its largest value.
    assign w_pos_next = (&r_pos) ? r_pos : r_pos + 32'd1;

    always_comb begin
        logic [mss_pkg::OFF_BITS:0] w_c;
        logic                       w_ge;
        w_match = '1;
        for (int k = 0; k < MAX_SIG_LEN; k++) begin
            w_match = w_match & w_eq[k];
        end
        for (int s = 0; s < NUM_SIGS; s++) begin
            // Match start plus offset, folded as count + (offset - length).
            w_c      = {1'b0, w_cfg.offs[mss_pkg::OFF_BITS*s +: mss_pkg::OFF_BITS]}
                       - {{(mss_pkg::OFF_BITS+1-LB){1'b0}}, w_len[s]};
            w_rel[s] = {1'b0, w_pos_next}
                       + {{(RB-mss_pkg::OFF_BITS-1){w_c[mss_pkg::OFF_BITS]}}, w_c};
            w_ge     = (w_pos_next[mss_pkg::POS_BITS-1:LB] != '0)
                       || (w_pos_next[LB-1:0] >= w_len[s]);
            w_hit[s] = (w_len[s] != '0) && !r_found[s] && w_ge && w_match[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_found     <= '0;
            r_pend      <= '0;
            r_rep_found <= '0;
            r_s2_end    <= 1'b0;
        end else if (w_take) begin
            r_pend   <= w_hit;
            r_s2_end <= i_in_data.end_of_image;
            if (i_in_data.end_of_image) begin
                r_pos       <= '0;
                r_found     <= '0;
                r_rep_found <= r_found | w_hit;
            end else begin
                r_pos   <= w_pos_next;
                r_found <= r_found | w_hit;
            end
        end else begin
            r_pend <= '0;
            if (w_load) begin
                r_s2_end <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            for (int s = 0; s < NUM_SIGS; s++) begin
                r_rel[s] <= w_rel[s];
            end
        end
    end

    // Second stage: add the base address, wrapping at the address width.
    always_comb begin
        for (int s = 0; s < NUM_SIGS; s++) begin
            w_sum[s] = w_cfg.base + {{(AB-RB){1'b0}}, r_rel[s]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NUM_SIGS; s++) begin
            if (r_pend[s]) begin
                r_addr[s] <= w_sum[s];
            end
        end
    end

    always_comb begin
        w_rep = '0;
        for (int s = 0; s < NUM_SIGS; s++) begin
            w_rep.found[s] = r_rep_found[s];
            if (r_rep_found[s]) begin
                w_rep.addr[s] = r_pend[s] ? w_sum[s] : r_addr[s];
            end
        end
    end

    mss_report #(.NUM_SIGS(NUM_SIGS)) u_report (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_rep   (w_rep),
        .o_free  (w_rep_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

// ===== hdl/mss_checker.sv =====
// ----------------------------------------------------------------------------
// Masked signature scanner port checker
// Watches the top level's ports for ordering and content of result words.
// ----------------------------------------------------------------------------
`include "masked_signature_scanner_top_macros.svh"

module mss_checker #(
    parameter int NUM_SIGS = mss_pkg::NUM_SIGS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mss_pkg::t_out_word o_out_data
);

    localparam logic [mss_pkg::IDX_BITS-1:0] LAST = mss_pkg::IDX_BITS'(NUM_SIGS - 1);

    `MSS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data),
        "result word changed while stalled")

    `MSS_ASSERT_NXT(a_index_step, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && !o_out_data.last_result,
        o_out_valid && (o_out_data.sig_index == $past(o_out_data.sig_index) + 2'd1),
        "result words of one image are not consecutive")

    `MSS_ASSERT_IMP(a_last_index, i_clk, i_rst_n,
        o_out_valid, o_out_data.last_result == (o_out_data.sig_index == LAST),
        "last flag does not mark the final signature")

    `MSS_ASSERT_IMP(a_zero_addr, i_clk, i_rst_n,
        o_out_valid && !o_out_data.found, o_out_data.match_address == '0,
        "address of a signature not found is not zero")

    // The input only backs up while the result buffer still has words to hand out.
    `MSS_ASSERT_IMP(a_stall_busy, i_clk, i_rst_n,
        i_in_valid && o_in_stall, o_out_valid,
        "input stalled while no result word is pending")

endmodule

bind masked_signature_scanner_top mss_checker #(.NUM_SIGS(NUM_SIGS)) u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== tb/tb_masked_signature_scanner_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked signature scanner testbench
// Streams short images through the scanner under random idling on both sides.
// Each image's four signature reports are checked field by field against a
// scan model kept alongside the stimulus. The register settings change
// between images and also in the middle of an image.
// ----------------------------------------------------------------------------
module tb_masked_signature_scanner_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int LONG_HOLD      = 150;
    localparam int IDLE_PCT       = 16;
    localparam int MAX_REPORTED   = 10;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_BYTES    = 60;

    typedef struct {
        logic [mss_pkg::CFG_IDX_BITS-1:0]  index;
        logic [mss_pkg::CFG_DATA_BITS-1:0] value;
    } t_reg_write;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_in_valid  = 1'b0;
    logic                              o_in_stall;
    mss_pkg::t_in_word                 i_in_data   = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    mss_pkg::t_out_word                o_out_data;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [mss_pkg::CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [mss_pkg::CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    // Register contents as the scan model sees them.
    logic [63:0]                   sig_pattern [mss_pkg::SIG_SLOTS];
    logic [31:0]                   care_bits;
    logic [15:0]                   sig_lengths;
    logic [63:0]                   sig_offsets;
    logic [mss_pkg::ADDR_BITS-1:0] image_base;

    // Scan state of the current image.
    logic [7:0]                    recent_bytes [mss_pkg::MAX_SIG_LEN_DEF];
    logic [31:0]                   bytes_seen;
    logic [mss_pkg::SIG_SLOTS-1:0] sig_hit;
    logic [mss_pkg::ADDR_BITS-1:0] hit_address [mss_pkg::SIG_SLOTS];

    mss_pkg::t_in_word  image_words [$];
    mss_pkg::t_out_word expected_reports [$];
    t_reg_write         register_writes [$];

    int words_queued    = 0;
    int bytes_taken     = 0;
    int images_taken    = 0;
    int reports_checked = 0;
    int reports_found   = 0;
    int mismatch_count  = 0;
    int quiet_cycles    = 0;
    int send_idle_pct   = IDLE_PCT;
    int recv_idle_pct   = IDLE_PCT;
    bit pressure_on     = 1'b0;

    masked_signature_scanner_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int clamped_length(input int s);
        int len;
        len = sig_lengths[4*s +: 4];
        return (len > mss_pkg::MAX_SIG_LEN_DEF) ? mss_pkg::MAX_SIG_LEN_DEF : len;
    endfunction

    task automatic clear_scan_state();
        int k;
        for (k = 0; k < mss_pkg::MAX_SIG_LEN_DEF; k++) recent_bytes[k] = '0;
        for (k = 0; k < mss_pkg::SIG_SLOTS; k++) hit_address[k] = '0;
        bytes_seen = '0;
        sig_hit    = '0;
    endtask

    // Shifts one image byte into the window, records first matches, and on the
    // end of an image queues the four reports that it must produce.
    task automatic scan_byte(input mss_pkg::t_in_word w);
        int                            s, i, len;
        logic                          match;
        logic [mss_pkg::ADDR_BITS-1:0] start;
        mss_pkg::t_out_word            rep;
        for (i = mss_pkg::MAX_SIG_LEN_DEF - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
        recent_bytes[0] = w.image_byte;
        if (bytes_seen != 32'hFFFF_FFFF) bytes_seen = bytes_seen + 1;
        for (s = 0; s < mss_pkg::SIG_SLOTS; s++) begin
            len = clamped_length(s);
            if (len != 0 && !sig_hit[s] && bytes_seen >= len) begin
                match = 1'b1;
                for (i = 0; i < len; i++) begin
                    if (care_bits[8*s+i] && recent_bytes[len-1-i] != sig_pattern[s][8*i +: 8])
                        match = 1'b0;
                end
                if (match) begin
                    start          = bytes_seen - len;
                    hit_address[s] = image_base + start + sig_offsets[16*s +: 16];
                    sig_hit[s]     = 1'b1;
                end
            end
        end
        if (w.end_of_image) begin
            for (s = 0; s < mss_pkg::SIG_SLOTS; s++) begin
                rep.sig_index     = s;
                rep.found         = sig_hit[s];
                rep.match_address = sig_hit[s] ? hit_address[s] : '0;
                rep.last_result   = (s == mss_pkg::SIG_SLOTS - 1);
                expected_reports  = {expected_reports, rep};
            end
            clear_scan_state();
        end
    endtask

    task automatic queue_word(input logic [7:0] b, input bit last);
        mss_pkg::t_in_word w;
        w.image_byte   = b;
        w.end_of_image = last;
        image_words    = {image_words, w};
        words_queued++;
    endtask

    // Random image, usually with one signature planted at a random place;
    // a planted copy may run past the end of the image and must not match.
    task automatic queue_image(input int n, input bit finish);
        logic [7:0] img [48];
        int         k, s, j, len, at;
        for (k = 0; k < n; k++) begin
            s = $urandom_range(0, mss_pkg::SIG_SLOTS - 1);
            j = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0)
                img[k] = sig_pattern[s][8*j +: 8];
            else
                img[k] = $urandom_range(0, 255);
        end
        if ($urandom_range(0, 9) < 7) begin
            s   = $urandom_range(0, mss_pkg::SIG_SLOTS - 1);
            len = clamped_length(s);
            if (len == 0) len = mss_pkg::MAX_SIG_LEN_DEF;
            at  = $urandom_range(0, n - 1);
            for (k = 0; k < len && at + k < n; k++) begin
                if (care_bits[8*s+k]) img[at+k] = sig_pattern[s][8*k +: 8];
            end
        end
        for (k = 0; k < n; k++) queue_word(img[k], finish && (k == n - 1));
    endtask

    task automatic add_write(input logic [mss_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [63:0] val);
        t_reg_write wr;
        wr.index        = idx;
        wr.value        = val;
        register_writes = {register_writes, wr};
    endtask

    // Must be entered right after a rising edge; returns on the edge that
    // took the last write.
    task automatic apply_register_writes();
        t_reg_write wr;
        while (register_writes.size() != 0) begin
            wr = register_writes.pop_front();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= wr.index;
            i_cfg_data  <= wr.value;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (wr.index)
                mss_pkg::CFG_PATTERN_ZERO:  sig_pattern[0] = wr.value;
                mss_pkg::CFG_PATTERN_ONE:   sig_pattern[1] = wr.value;
                mss_pkg::CFG_PATTERN_TWO:   sig_pattern[2] = wr.value;
                mss_pkg::CFG_PATTERN_THREE: sig_pattern[3] = wr.value;
                mss_pkg::CFG_CARE_MASKS:    care_bits      = wr.value[31:0];
                mss_pkg::CFG_LENGTHS:       sig_lengths    = wr.value[15:0];
                mss_pkg::CFG_OFFSETS:       sig_offsets    = wr.value;
                mss_pkg::CFG_BASE_ADDRESS:  image_base     = wr.value[mss_pkg::ADDR_BITS-1:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] pick_wide();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic randomize_settings();
        logic [31:0] care;
        logic [15:0] lens;
        logic [63:0] r;
        int          s;
        for (s = 0; s < mss_pkg::SIG_SLOTS; s++)
            add_write(mss_pkg::CFG_PATTERN_ZERO + s, pick_wide());
        for (s = 0; s < mss_pkg::SIG_SLOTS; s++) begin
            case ($urandom_range(0, 4))
                0:       care[8*s +: 8] = 8'hFF;
                1:       care[8*s +: 8] = 8'h00;
                default: care[8*s +: 8] = $urandom_range(0, 255);
            endcase
            case ($urandom_range(0, 9))
                0:       lens[4*s +: 4] = 4'd0;
                1:       lens[4*s +: 4] = $urandom_range(9, 15);
                default: lens[4*s +: 4] = $urandom_range(1, 8);
            endcase
        end
        add_write(mss_pkg::CFG_CARE_MASKS, {$urandom, care});
        add_write(mss_pkg::CFG_LENGTHS, {48'd0, lens});
        add_write(mss_pkg::CFG_OFFSETS, pick_wide());
        r = pick_wide();
        // Bases just under the top of the address space make the sums wrap.
        if ($urandom_range(0, 3) == 0) r = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 40);
        add_write(mss_pkg::CFG_BASE_ADDRESS, r);
        // Indexes past the base address register are unmapped.
        if ($urandom_range(0, 2) == 0)
            add_write(mss_pkg::CFG_BASE_ADDRESS + 1 + $urandom_range(0, 7), pick_wide());
    endtask

    task automatic wait_until_drained();
        while (bytes_taken != words_queued || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input mss_pkg::t_out_word want,
                                 input mss_pkg::t_out_word got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED) begin
            $display("%s: expected sig %0d found %0b addr %h last %0b", what,
                     want.sig_index, want.found, want.match_address, want.last_result);
            $display("    actual sig %0d found %0b addr %h last %0b",
                     got.sig_index, got.found, got.match_address, got.last_result);
        end
    endtask

    // Image byte driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                scan_byte(i_in_data);
                bytes_taken++;
                if (i_in_data.end_of_image) images_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (image_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= image_words.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Report monitor and output stall.
    always @(posedge i_clk) begin : report_monitor
        mss_pkg::t_out_word want;
        int                 hold_left;
        bit                 hold_done;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                reports_checked++;
                if (expected_reports.size() == 0) begin
                    note_mismatch("Result word with nothing pending", '0, o_out_data);
                end else begin
                    want = expected_reports.pop_front();
                    if (want.found) reports_found++;
                    if (want.sig_index !== o_out_data.sig_index ||
                        want.found !== o_out_data.found ||
                        want.match_address !== o_out_data.match_address ||
                        want.last_result !== o_out_data.last_result)
                        note_mismatch("Result word differs", want, o_out_data);
                end
            end
            // One long hold lets the result buffer fill and back up the input.
            if (pressure_on && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int k, phase, n, len;
        for (k = 0; k < mss_pkg::SIG_SLOTS; k++) sig_pattern[k] = '0;
        care_bits   = '0;
        sig_lengths = '0;
        sig_offsets = '0;
        image_base  = '0;
        clear_scan_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Signature zero: four zero bytes, all compared. Signature one: eight
        // 0xFF bytes with an over-range length. Signature two: one wildcard
        // byte whose address wraps to zero. Signature three: disabled.
        add_write(mss_pkg::CFG_PATTERN_ZERO, 64'h0);
        add_write(mss_pkg::CFG_PATTERN_ONE, 64'hFFFF_FFFF_FFFF_FFFF);
        add_write(mss_pkg::CFG_PATTERN_TWO, 64'h0123_4567_89AB_CDEF);
        add_write(mss_pkg::CFG_PATTERN_THREE, 64'hA5A5_A5A5_A5A5_A5A5);
        add_write(mss_pkg::CFG_CARE_MASKS, 64'hFF00_FFFF);
        add_write(mss_pkg::CFG_LENGTHS, {48'd0, 4'd0, 4'd1, 4'd15, 4'd4});
        add_write(mss_pkg::CFG_OFFSETS, 64'hFFFF_0001_FFFF_0000);
        add_write(mss_pkg::CFG_BASE_ADDRESS, 64'h0000_FFFF_FFFF_FFFF);
        add_write(mss_pkg::CFG_BASE_ADDRESS + 1, '1);
        apply_register_writes();

        // Three zero bytes are too few for signature zero, even though the
        // cleared window already holds zeros.
        for (k = 0; k < 3; k++) queue_word(8'h00, k == 2);
        for (k = 0; k < 4; k++) queue_word(8'h00, k == 3);
        // Seven of eight bytes at the end of the image must not match.
        for (k = 0; k < 7; k++) queue_word(8'hFF, k == 6);
        queue_word(8'h12, 1'b0);
        for (k = 0; k < 8; k++) queue_word(8'hFF, k == 7);
        queue_word(8'h5A, 1'b1);
        wait_until_drained();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            randomize_settings();
            apply_register_writes();
            pressure_on   = (phase == 2);
            send_idle_pct = (phase == 3) ? 0 : IDLE_PCT;
            recv_idle_pct = (phase == 3) ? 0 : IDLE_PCT;
            n = 0;
            while (n < PHASE_BYTES) begin
                if (phase == 2)
                    len = $urandom_range(1, 6);
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(17, 40);
                else
                    len = $urandom_range(1, 16);
                queue_image(len, 1'b1);
                n += len;
            end
            // Leave an image open so that the next settings land mid-scan.
            if ($urandom_range(0, 1) == 1) queue_image($urandom_range(1, 5), 1'b0);
            wait_until_drained();
        end

        $display("Scanned %0d bytes in %0d images over %0d register settings.",
                 bytes_taken, images_taken, RANDOM_PHASES + 1);
        $display("Checked %0d signature reports, %0d found; one long output hold.",
                 reports_checked, reports_found);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== masked_signature_scanner_top.f =====
+incdir+hdl
hdl/mss_pkg.sv
hdl/mss_cell.sv
hdl/mss_cfg_regs.sv
hdl/mss_report.sv
hdl/masked_signature_scanner_top.sv
hdl/mss_checker.sv
tb/tb_masked_signature_scanner_top.sv
